// ----- rtl/md5_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 message hasher.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  BLOCK_MASK = 6'h3F;
    localparam int          QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } md5_in_t;

    typedef struct packed {
        logic [63:0] digest_low;
        logic [63:0] digest_high;
    } md5_out_t;

    // queue entry: an item already classified by the front part
    typedef struct packed {
        logic [7:0] data_byte;
        logic       absorb;
        logic       finish;
    } md5_cmd_t;

    typedef enum logic [2:0] {
        ST_TAKE,
        ST_MARK,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_EMIT
    } md5_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] round_g(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(5 * r[3:0] + 1);
            2'd2: g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/md5_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface md5_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/md5_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-write RAM with registered read.
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- rtl/md5_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_front
// Accepts input transfers, drops idle items and queues the rest as commands.
// ----------------------------------------------------------------------------
module md5_front #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    md5_stream_if.sink       in_ch,
    output md5_pkg::md5_cmd_t cmd,
    output logic             cmd_valid,
    input  logic             cmd_take
);
    import md5_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    md5_cmd_t         q_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             push, pop;
    md5_in_t          item;

    assign item = in_ch.payload;
    assign in_ch.ready = (cnt_reg != (AW+1)'(QUEUE_DEPTH));
    assign push = in_ch.valid && in_ch.ready && (item.has_byte || item.is_last);
    assign cmd_valid = (cnt_reg != '0);
    assign pop = cmd_valid && cmd_take;
    assign cmd = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= '{data_byte: item.data_byte, absorb: item.has_byte,
                               finish: item.is_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ----- rtl/md5_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_back
// Buffers bytes, pads, runs one MD5 round per cycle and emits the digest.
// ----------------------------------------------------------------------------
module md5_back (
    input  logic              clk,
    input  logic              rst_n,
    input  md5_pkg::md5_cmd_t cmd,
    input  logic              cmd_valid,
    output logic              cmd_take,
    md5_stream_if.source      out_ch
);
    import md5_pkg::*;

    md5_state_t  state_reg, state_next;
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] bits_reg;
    logic [5:0]  fill_reg;     // pad write pointer
    logic [6:0]  rnd_reg;      // 0..64, round 64 = final add
    logic        fin_reg;      // finishing a message
    logic        mark_reg;     // pad marker already written
    logic        lenpass_reg;  // current compression carries the length
    logic        out_valid_reg;
    md5_out_t    out_reg;

    logic        ram_we;
    logic [5:0]  ram_wa;
    logic [7:0]  ram_wd;
    logic [5:0]  ram_ra0, ram_ra1, ram_ra2, ram_ra3;
    logic [7:0]  rd0, rd1, rd2, rd3;
    logic [31:0] w_word, f_val, t_val, rot_val;
    logic [3:0]  g_next;
    logic [5:0]  bfill;
    logic [63:0] bits_inc;
    logic        emit_fire;

    assign bfill = bits_reg[8:3];
    assign bits_inc = bits_reg + 64'd8;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);

    // four byte lanes read the word needed by the next round
    always_comb
    begin
        g_next  = round_g(rnd_reg[5:0] + 6'd1);
        if (state_reg != ST_COMP)
        begin
            g_next = 4'd0;
        end
        ram_ra0 = {g_next, 2'd0};
        ram_ra1 = {g_next, 2'd1};
        ram_ra2 = {g_next, 2'd2};
        ram_ra3 = {g_next, 2'd3};
    end

    md5_ram #(.WIDTH(8), .DEPTH(64)) u_ram0 (.clk(clk), .wr_en(ram_we), .wr_addr(ram_wa),
        .wr_data(ram_wd), .rd_addr(ram_ra0), .rd_data(rd0));
    md5_ram #(.WIDTH(8), .DEPTH(64)) u_ram1 (.clk(clk), .wr_en(ram_we), .wr_addr(ram_wa),
        .wr_data(ram_wd), .rd_addr(ram_ra1), .rd_data(rd1));
    md5_ram #(.WIDTH(8), .DEPTH(64)) u_ram2 (.clk(clk), .wr_en(ram_we), .wr_addr(ram_wa),
        .wr_data(ram_wd), .rd_addr(ram_ra2), .rd_data(rd2));
    md5_ram #(.WIDTH(8), .DEPTH(64)) u_ram3 (.clk(clk), .wr_en(ram_we), .wr_addr(ram_wa),
        .wr_data(ram_wd), .rd_addr(ram_ra3), .rd_data(rd3));

    assign w_word = {rd3, rd2, rd1, rd0};

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_val = a_reg + f_val + w_word + round_k(rnd_reg[5:0]);
        rot_val = (t_val << round_s(rnd_reg[5:0])) |
                  (t_val >> (6'd32 - {1'b0, round_s(rnd_reg[5:0])}));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_TAKE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.absorb && bfill == BLOCK_MASK)
                        state_next = ST_COMP;
                    else if (cmd.finish)
                        state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (bfill == BLOCK_MASK)
                    state_next = ST_COMP;
                else if (bfill == 6'd55)
                    state_next = ST_LEN;
                else
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                if (lenpass_reg && fill_reg == 6'd55)
                    state_next = ST_LEN;
                else if (!lenpass_reg && fill_reg == 6'd63)
                    state_next = ST_COMP;
            end
            ST_LEN:
            begin
                if (fill_reg == 6'd63)
                    state_next = ST_COMP;
            end
            ST_COMP:
            begin
                if (rnd_reg == 7'd64)
                begin
                    if (!fin_reg)
                        state_next = ST_TAKE;
                    else if (lenpass_reg)
                        state_next = ST_EMIT;
                    else if (!mark_reg)
                        state_next = ST_MARK;
                    else
                        state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                    state_next = ST_TAKE;
            end
            default: state_next = ST_TAKE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_take = 1'b0;
        ram_we = 1'b0;
        ram_wa = fill_reg;
        ram_wd = 8'h00;
        case (state_reg)
            ST_TAKE:
            begin
                cmd_take = cmd_valid;
                if (cmd_valid && cmd.absorb)
                begin
                    ram_we = 1'b1;
                    ram_wa = bfill;
                    ram_wd = cmd.data_byte;
                end
            end
            ST_MARK:
            begin
                ram_we = 1'b1;
                ram_wa = bfill;
                ram_wd = PAD_MARK;
            end
            ST_PAD:
            begin
                ram_we = 1'b1;
            end
            ST_LEN:
            begin
                ram_we = 1'b1;
                ram_wd = bits_reg[8 * fill_reg[2:0] +: 8];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TAKE;
            h_reg[0]      <= IV_A;
            h_reg[1]      <= IV_B;
            h_reg[2]      <= IV_C;
            h_reg[3]      <= IV_D;
            bits_reg      <= '0;
            fill_reg      <= '0;
            rnd_reg       <= '0;
            fin_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            lenpass_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            rnd_reg <= (state_reg == ST_COMP && rnd_reg != 7'd64) ? rnd_reg + 7'd1 : '0;
            case (state_reg)
                ST_TAKE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.absorb)
                        begin
                            bits_reg <= bits_inc;
                        end
                        fin_reg     <= cmd.finish;
                        mark_reg    <= 1'b0;
                        lenpass_reg <= 1'b0;
                    end
                end
                ST_MARK:
                begin
                    mark_reg    <= 1'b1;
                    fill_reg    <= bfill + 6'd1;
                    lenpass_reg <= (bfill < 6'd56);
                end
                ST_PAD:
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
                ST_LEN:
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
                ST_COMP:
                begin
                    if (rnd_reg == 7'd64)
                    begin
                        h_reg[0] <= h_reg[0] + a_reg;
                        h_reg[1] <= h_reg[1] + b_reg;
                        h_reg[2] <= h_reg[2] + c_reg;
                        h_reg[3] <= h_reg[3] + d_reg;
                        if (fin_reg && mark_reg && !lenpass_reg)
                        begin
                            // second block: zeros from byte 0, then the length
                            lenpass_reg <= 1'b1;
                            fill_reg    <= '0;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (emit_fire)
                    begin
                        h_reg[0] <= IV_A;
                        h_reg[1] <= IV_B;
                        h_reg[2] <= IV_C;
                        h_reg[3] <= IV_D;
                        bits_reg <= '0;
                        fin_reg  <= 1'b0;
                        mark_reg <= 1'b0;
                        lenpass_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working variables and digest payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COMP && rnd_reg != 7'd64)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot_val;
        end
        else
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
        end
        if (emit_fire)
        begin
            out_reg.digest_low  <= {h_reg[1], h_reg[0]};
            out_reg.digest_high <= {h_reg[3], h_reg[2]};
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;
endmodule

// ----- rtl/md5_message_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_message_hasher
// Byte-stream MD5: front queue of commands, back unit with one round a cycle.
// ----------------------------------------------------------------------------
// channel   dir   payload
// in_ch     sink  data_byte[7:0], has_byte, is_last
// out_ch    src   digest_low[63:0], digest_high[63:0]
//
// The back unit takes one byte per cycle while in ST_TAKE; the 64th byte
// of a block starts a compression (one MD5 round per cycle plus the chaining
// add). Finishing writes the 0x80 marker, then zeros and the length one byte a
// cycle up to byte 63, runs one or two compressions, then loads the digest
// register, waiting there while the previous digest stalls.
// Reset loads the initial chaining words and clears the count; no sweep.
// Input stalls only when the command queue is full.
// ----------------------------------------------------------------------------
module md5_message_hasher #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    md5_stream_if.sink   in_ch,
    md5_stream_if.source out_ch
);
    import md5_pkg::*;

    md5_cmd_t cmd;
    logic     cmd_valid, cmd_take;

    md5_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    md5_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .out_ch(out_ch)
    );
endmodule
